// ===== design/ihtp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ihtp_pkg
// shared constants and types for the ipv4 host text parser
// ----------------------------------------------------------------------------
package ihtp_pkg;

    localparam int CHAR_W   = 8;
    localparam int ACC_W    = 64;
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 3;

    localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_X_LO = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_X_UP = 8'h58;

    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_OCT,
        RADIX_HEX
    } t_radix;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_TOO_MANY = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_INVALID  = 3'd3,
        ST_OVERFLOW = 3'd4
    } t_status;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        t_status           status;
    } t_result;

    typedef struct packed {
        logic [ACC_W-1:0] value;
        logic             ok;
    } t_acc_out;

endpackage
`default_nettype wire

// ===== design/ipv4_host_text_parser_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_host_text_parser_top
// streaming parser of dotted ipv4 host text into a 32-bit address
// ----------------------------------------------------------------------------
// Host text enters one byte per request, tlast on its last byte, and the
// block takes one byte every cycle. The per-byte work (digit decode and the
// radix multiply-add into the 64-bit segment accumulator, then the address
// checks on the last byte) sits between the input register and the result
// register, so a result is offered from the result register once its last
// byte has left the input register. Only the last byte of a text makes a result;
// while a result waits on the output, bytes that are not last still flow, and
// a last byte waits in the input register until the output register frees.
module ipv4_host_text_parser_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output      logic                          o_s_axis_tready,
    input  wire logic [ihtp_pkg::CHAR_W-1:0]   i_s_axis_tdata,  // [7:0] character
    input  wire logic                          i_s_axis_tlast,  // final_char
    output      logic                          o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output      logic [ihtp_pkg::ADDR_W-1:0]   o_m_axis_tdata,  // [31:0] address
    output      logic [ihtp_pkg::STATUS_W-1:0] o_m_axis_tuser   // [2:0] status
);

    logic                        r_in_valid;
    logic [ihtp_pkg::CHAR_W-1:0] r_in_char;
    logic                        r_in_last;
    logic                        r_out_valid;
    ihtp_pkg::t_result           r_out_result;

    logic              out_free;
    logic              step;
    ihtp_pkg::t_result core_result;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && (!r_in_last || out_free);
    assign o_s_axis_tready = !r_in_valid || step;

    ihtp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_char   (r_in_char),
        .i_last   (r_in_last),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (step && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_char <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
        if (step && r_in_last) begin
            r_out_result <= core_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_result.address;
    assign o_m_axis_tuser  = r_out_result.status;

endmodule
`default_nettype wire

// ===== design/ihtp_accum.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ihtp_accum
// digit decode and constant-radix multiply-add of the segment accumulator
// ----------------------------------------------------------------------------
module ihtp_accum (
    input  wire logic [ihtp_pkg::ACC_W-1:0]  i_acc,
    input  wire logic [ihtp_pkg::CHAR_W-1:0] i_char,
    input  wire ihtp_pkg::t_radix            i_radix,
    output ihtp_pkg::t_acc_out               o_res
);

    localparam int WIDE_W = ihtp_pkg::ACC_W + 4;

    logic              d_valid;
    logic              d_in_base;
    logic [3:0]        d_val;
    logic [WIDE_W-1:0] ext;
    logic [WIDE_W-1:0] dig;
    logic [WIDE_W-1:0] sum;

    always_comb begin
        d_valid = 1'b0;
        d_val   = 4'd0;
        if (i_char >= 8'h30 && i_char <= 8'h39) begin
            d_valid = 1'b1;
            d_val   = i_char[3:0];
        end else if ((i_char >= 8'h61 && i_char <= 8'h66) ||
                     (i_char >= 8'h41 && i_char <= 8'h46)) begin
            // low nibble of a..f / A..F is 1..6
            d_valid = 1'b1;
            d_val   = i_char[3:0] + 4'd9;
        end
    end

    assign ext = {4'b0000, i_acc};
    assign dig = {{(WIDE_W-4){1'b0}}, d_val};

    always_comb begin
        case (i_radix)
            ihtp_pkg::RADIX_DEC: begin
                d_in_base = (d_val < 4'd10);
                sum       = (ext << 3) + (ext << 1) + dig;
            end
            ihtp_pkg::RADIX_OCT: begin
                d_in_base = (d_val < 4'd8);
                sum       = (ext << 3) + dig;
            end
            ihtp_pkg::RADIX_HEX: begin
                d_in_base = 1'b1;
                sum       = (ext << 4) + dig;
            end
            default: begin
                d_in_base = 1'b0;
                sum       = '0;
            end
        endcase
    end

    // carry out of 64 bits means the segment no longer fits
    assign o_res.ok    = d_valid && d_in_base && (sum[WIDE_W-1:ihtp_pkg::ACC_W] == 4'd0);
    assign o_res.value = sum[ihtp_pkg::ACC_W-1:0];

endmodule
`default_nettype wire

// ===== design/ihtp_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ihtp_core
// per-character segment state and evaluation of the final address
// ----------------------------------------------------------------------------
module ihtp_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic [ihtp_pkg::CHAR_W-1:0] i_char,
    input  wire logic                        i_last,
    output ihtp_pkg::t_result                o_result
);

    typedef enum logic [2:0] {
        PH_START,
        PH_ZERO,
        PH_DEC,
        PH_OCT,
        PH_HEX,
        PH_DEAD
    } t_phase;

    t_phase                       r_phase, n_phase;
    logic [2:0]                   r_count, n_count;
    logic [1:0]                   r_chars, n_chars;
    ihtp_pkg::t_status            r_err, n_err;
    logic [ihtp_pkg::ACC_W-1:0]   r_acc, n_acc;
    logic [7:0]                   r_seg_lo  [3];
    logic [7:0]                   n_seg_lo  [3];
    logic [2:0]                   r_seg_big, n_seg_big;

    ihtp_pkg::t_radix   radix;
    ihtp_pkg::t_acc_out acc_out;

    always_comb begin
        case (r_phase)
            PH_ZERO, PH_OCT: radix = ihtp_pkg::RADIX_OCT;
            PH_HEX:          radix = ihtp_pkg::RADIX_HEX;
            default:         radix = ihtp_pkg::RADIX_DEC;
        endcase
    end

    ihtp_accum u_accum (
        .i_acc   (r_acc),
        .i_char  (i_char),
        .i_radix (radix),
        .o_res   (acc_out)
    );

    always_comb begin
        logic              take_acc;
        ihtp_pkg::t_status fin_err;
        logic              prev_big;
        logic              last_big;
        logic [31:0]       addr;

        n_phase   = r_phase;
        n_count   = r_count;
        n_chars   = r_chars;
        n_err     = r_err;
        n_acc     = r_acc;
        n_seg_lo  = r_seg_lo;
        n_seg_big = r_seg_big;
        take_acc  = 1'b0;

        // after a fourth dot the text is ignored until its last byte
        if (i_step && !r_count[2]) begin
            if (i_char == ihtp_pkg::CHAR_DOT) begin
                if (r_chars == 2'd0 && r_err == ihtp_pkg::ST_OK) begin
                    n_err = ihtp_pkg::ST_EMPTY;
                end
                if (r_count < 3'd3) begin
                    n_seg_lo[r_count[1:0]]  = r_acc[7:0];
                    n_seg_big[r_count[1:0]] = |r_acc[ihtp_pkg::ACC_W-1:8];
                end
                n_phase = PH_START;
                n_chars = 2'd0;
                n_acc   = '0;
                n_count = r_count + 3'd1;
            end else begin
                case (r_phase)
                    PH_START: begin
                        if (i_char == ihtp_pkg::CHAR_ZERO) begin
                            n_acc   = '0;
                            n_phase = PH_ZERO;
                        end else begin
                            n_phase  = PH_DEC;
                            take_acc = 1'b1;
                        end
                    end
                    PH_ZERO: begin
                        if (i_char == ihtp_pkg::CHAR_X_LO || i_char == ihtp_pkg::CHAR_X_UP) begin
                            n_phase = PH_HEX;
                        end else begin
                            n_phase  = PH_OCT;
                            take_acc = 1'b1;
                        end
                    end
                    PH_DEC, PH_OCT, PH_HEX: begin
                        take_acc = 1'b1;
                    end
                    default: begin
                        take_acc = 1'b0;
                    end
                endcase
                if (take_acc) begin
                    if (acc_out.ok) begin
                        n_acc = acc_out.value;
                    end else begin
                        if (r_err == ihtp_pkg::ST_OK) begin
                            n_err = ihtp_pkg::ST_INVALID;
                        end
                        n_phase = PH_DEAD;
                    end
                end
                if (r_chars != 2'd3) begin
                    n_chars = r_chars + 2'd1;
                end
            end
        end

        // evaluation on the state that includes the last byte
        fin_err = n_err;
        if (n_chars == 2'd0 && fin_err == ihtp_pkg::ST_OK) begin
            fin_err = ihtp_pkg::ST_EMPTY;
        end
        prev_big = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (3'(i) < n_count) begin
                prev_big = prev_big | n_seg_big[i];
            end
        end
        case (n_count[1:0])
            2'd0: begin
                last_big = |n_acc[63:32];
                addr     = n_acc[31:0];
            end
            2'd1: begin
                last_big = |n_acc[63:24];
                addr     = {n_seg_lo[0], n_acc[23:0]};
            end
            2'd2: begin
                last_big = |n_acc[63:16];
                addr     = {n_seg_lo[0], n_seg_lo[1], n_acc[15:0]};
            end
            default: begin
                last_big = |n_acc[63:8];
                addr     = {n_seg_lo[0], n_seg_lo[1], n_seg_lo[2], n_acc[7:0]};
            end
        endcase

        o_result.address = '0;
        if (n_count[2]) begin
            o_result.status = ihtp_pkg::ST_TOO_MANY;
        end else if (fin_err != ihtp_pkg::ST_OK) begin
            o_result.status = fin_err;
        end else if (prev_big || last_big) begin
            o_result.status = ihtp_pkg::ST_OVERFLOW;
        end else begin
            o_result.status  = ihtp_pkg::ST_OK;
            o_result.address = addr;
        end

        // the last byte leaves the parser ready for new text
        if (i_step && i_last) begin
            n_phase = PH_START;
            n_count = 3'd0;
            n_chars = 2'd0;
            n_err   = ihtp_pkg::ST_OK;
            n_acc   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_count <= 3'd0;
            r_chars <= 2'd0;
            r_err   <= ihtp_pkg::ST_OK;
            r_acc   <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_chars <= n_chars;
            r_err   <= n_err;
            r_acc   <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seg_lo  <= n_seg_lo;
        r_seg_big <= n_seg_big;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("segment count above four");

    a_empty_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_chars == 2'd0) |-> (r_phase == PH_START))
        else $error("empty segment not at segment start");

    a_zero_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ZERO || r_phase == PH_START) |-> (r_acc == '0))
        else $error("accumulator not clear at segment start");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_last) |=>
            (r_count == 3'd0 && r_chars == 2'd0 && r_err == ihtp_pkg::ST_OK))
        else $error("state not cleared after last byte");

endmodule
`default_nettype wire
